FILE: design/assert_macros.svh
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define LCSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lcsp: property violated");

// Check on every clock edge, reset included.
`define LCSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lcsp: property violated during reset");

`endif

FILE: design/lcsp_pkg.sv
// Shared constants and types of the LCS length and positions unit.
package lcsp_pkg;

  localparam int unsigned MAX_LEN_DEF    = 32;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  localparam int unsigned ELEM_FIELD_W = 16;
  localparam int unsigned LEN_FIELD_W  = 6;
  localparam int unsigned POS_FIELD_W  = 5;

  localparam int unsigned RESULT_CAP = 32;

  typedef struct packed {
    logic vld;
    logic first_row;
    logic first_col;
  } cell_ctrl_t;

endpackage

FILE: design/lcsp_ifs.sv
// Valid/ready channel interfaces for element pairs in and result transactions out.
interface lcsp_in_if import lcsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ELEM_FIELD_W-1:0] elem_a;
  logic [ELEM_FIELD_W-1:0] elem_b;
  logic                    last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface lcsp_out_if import lcsp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LEN_FIELD_W-1:0] lcs_length;
  logic [POS_FIELD_W-1:0] pos_a;
  logic [POS_FIELD_W-1:0] pos_b;
  logic                   pair_valid;
  logic                   overflow;
  logic                   run_end;

  modport source (output valid, output lcs_length, output pos_a, output pos_b,
                  output pair_valid, output overflow, output run_end, input ready);
  modport sink   (input valid, input lcs_length, input pos_a, input pos_b,
                  input pair_valid, input overflow, input run_end, output ready);
endinterface

FILE: design/lcsp_cell_unit.sv
// Score cell update engine: one DP cell per cycle with running left and diagonal values.
module lcsp_cell_unit import lcsp_pkg::*; #(
  parameter int unsigned SW = 6,
  parameter int unsigned EW = ELEM_WIDTH_DEF
) (
  input  logic          clk_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [EW-1:0] a_i,
  input  logic [EW-1:0] b_i,
  input  logic [SW-1:0] up_i,
  output logic [SW-1:0] score_o
);

  logic [SW-1:0] left_q, diag_q;
  logic [SW-1:0] up, left, diag;

  // Row zero and column zero of the table are all zero.
  assign up   = ctrl_i.first_row ? '0 : up_i;
  assign left = ctrl_i.first_col ? '0 : left_q;
  assign diag = ctrl_i.first_col ? '0 : diag_q;

  always_comb begin
    if (a_i == b_i) begin
      score_o = diag + 1'b1;
    end else begin
      score_o = (up > left) ? up : left;
    end
  end

  // The up value of this column is the diagonal of the next one.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      left_q <= score_o;
      diag_q <= up;
    end
  end

endmodule

FILE: design/lcs_length_and_positions_unit.sv
// Top level of the LCS length and positions unit.
// Element pairs arrive one transaction each until one carries last; pairs past MAX_LEN are
// dropped and reported through the overflow flag. The last pair starts a run that takes no
// input: the score table is filled one cell a cycle through the shared cell unit and one
// read port of the score memory; the traceback walks back from the corner, each step
// reading in S_TB_RD and deciding in S_TB_EV; the two greedy position scans run side by
// side, each step reading in S_SC_RD and deciding in S_SC_EV; and each result passes
// through S_EM_RD, S_EM_LD and S_EM_WT, holding in S_EM_WT while the output stalls. All
// stores come up undefined and are written in a run before they are read, so no clearing
// pass follows reset. Results are the LCS length and one matched pair of positions each,
// at most RESULT_CAP of them; an empty answer gives a single result with pair_valid low.
// The last result of a run carries run_end.
`include "assert_macros.svh"

module lcs_length_and_positions_unit import lcsp_pkg::*; #(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcsp_in_if.sink    in_i,
  lcsp_out_if.source out_o
);

  localparam int unsigned IDXW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNTW   = $clog2(MAX_LEN + 1);
  localparam int unsigned SW     = CNTW;
  localparam int unsigned EW     = ELEM_WIDTH;
  localparam int unsigned TDEPTH = 1 << (2 * IDXW);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_FILL  = 9'b000000010,
    S_TB_RD = 9'b000000100,
    S_TB_EV = 9'b000001000,
    S_SC_RD = 9'b000010000,
    S_SC_EV = 9'b000100000,
    S_EM_RD = 9'b001000000,
    S_EM_LD = 9'b010000000,
    S_EM_WT = 9'b100000000
  } state_e;

  // ---------------------------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;          // pairs held, also n during a run
  logic            ovf_q, ovf_d;
  logic [CNTW-1:0] rr_q, rr_d, rc_q, rc_d; // fill read-issue row and column, one based
  logic            iss_q, iss_d;
  logic            cvld_q, cvld_d;         // fill compute stage holds a cell
  logic [CNTW-1:0] cr_q, cr_d, cc_q, cc_d;
  logic [SW-1:0]   len_q, len_d;
  logic [CNTW-1:0] tr_q, tr_d, tc_q, tc_d, tcnt_q, tcnt_d;
  logic [SW-1:0]   here_q, here_d;
  logic [CNTW-1:0] ka_q, ka_d, ia_q, ia_d, kb_q, kb_d, ib_q, ib_d;
  logic [CNTW-1:0] ek_q, ek_d;
  logic            ov_q, ov_d;

  // Output payload
  logic [LEN_FIELD_W-1:0] olen_q;
  logic [POS_FIELD_W-1:0] opa_q, opb_q;
  logic                   opv_q, oovf_q, oend_q;
  logic                   out_ld;
  logic                   em_last;

  // ---------------------------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------------------------
  logic [EW-1:0]   seq_a_q [MAX_LEN];
  logic [EW-1:0]   seq_b_q [MAX_LEN];
  logic [SW-1:0]   tab_q   [TDEPTH];
  logic [EW-1:0]   sub_q   [MAX_LEN];
  logic [IDXW-1:0] pa_q    [MAX_LEN];
  logic [IDXW-1:0] pb_q    [MAX_LEN];

  logic [EW-1:0]     a_rd_q, b_rd_q, sa_rd_q, sb_rd_q;
  logic [SW-1:0]     tab_rd0_q, tab_rd1_q;
  logic [IDXW-1:0]   pa_rd_q, pb_rd_q;

  logic              seq_we, tab_we, sub_we, pa_we, pb_we;
  logic [IDXW-1:0]   a_raddr, b_raddr;
  logic [2*IDXW-1:0] tab_ra0, tab_ra1, tab_waddr;

  logic              in_acc;
  logic              act_a, act_b;
  logic [SW-1:0]     score;
  logic [SW-1:0]     up_v, left_v;
  cell_ctrl_t        cell_ctrl;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;

  // Greedy scans stop at the sequence end or once every element is matched.
  assign act_a = (ka_q < cnt_q) && (ia_q < len_q);
  assign act_b = (kb_q < cnt_q) && (ib_q < len_q);

  assign em_last = (len_q == '0) || (({1'b0, ek_q} + 1'b1) == {1'b0, len_q}) ||
                   ((32'(ek_q) + 32'd1) == RESULT_CAP);

  assign tab_waddr = {IDXW'(cr_q - 1'b1), IDXW'(cc_q - 1'b1)};

  // Shared cell unit
  assign cell_ctrl.vld       = cvld_q;
  assign cell_ctrl.first_row = (cr_q == CNTW'(1));
  assign cell_ctrl.first_col = (cc_q == CNTW'(1));

  lcsp_cell_unit #(
    .SW (SW),
    .EW (EW)
  ) u_cell (
    .clk_i   (clk_i),
    .ctrl_i  (cell_ctrl),
    .a_i     (a_rd_q),
    .b_i     (b_rd_q),
    .up_i    (tab_rd0_q),
    .score_o (score)
  );

  // Traceback neighbors; row and column zero read as zero.
  assign up_v   = (tr_q == CNTW'(1)) ? '0 : tab_rd0_q;
  assign left_v = (tc_q == CNTW'(1)) ? '0 : tab_rd1_q;

  // ---------------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    rr_d    = rr_q;
    rc_d    = rc_q;
    iss_d   = iss_q;
    cvld_d  = (state_q == S_FILL) && iss_q;
    cr_d    = rr_q;
    cc_d    = rc_q;
    len_d   = len_q;
    tr_d    = tr_q;
    tc_d    = tc_q;
    tcnt_d  = tcnt_q;
    here_d  = here_q;
    ka_d    = ka_q;
    ia_d    = ia_q;
    kb_d    = kb_q;
    ib_d    = ib_q;
    ek_d    = ek_q;
    ov_d    = ov_q;
    out_ld  = 1'b0;
    seq_we  = 1'b0;
    tab_we  = 1'b0;
    sub_we  = 1'b0;
    pa_we   = 1'b0;
    pb_we   = 1'b0;
    a_raddr = IDXW'(ka_q);
    b_raddr = IDXW'(kb_q);
    tab_ra0 = {IDXW'(rr_q - CNTW'(2)), IDXW'(rc_q - 1'b1)};
    tab_ra1 = {IDXW'(tr_q - 1'b1), IDXW'(tc_q - CNTW'(2))};

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          // Store the pair while there is room, otherwise drop it and flag the run.
          if (cnt_q < CNTW'(MAX_LEN)) begin
            seq_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            rr_d    = CNTW'(1);
            rc_d    = CNTW'(1);
            iss_d   = 1'b1;
            state_d = S_FILL;
          end
        end
      end

      S_FILL: begin
        // Issue reads for cell (rr, rc) while the cell unit finishes the one before.
        a_raddr = IDXW'(rr_q - 1'b1);
        b_raddr = IDXW'(rc_q - 1'b1);
        if (iss_q) begin
          if (rc_q == cnt_q) begin
            rc_d = CNTW'(1);
            if (rr_q == cnt_q) begin
              iss_d = 1'b0;
            end else begin
              rr_d = rr_q + 1'b1;
            end
          end else begin
            rc_d = rc_q + 1'b1;
          end
        end
        if (cvld_q) begin
          tab_we = 1'b1;
          if ((cr_q == cnt_q) && (cc_q == cnt_q)) begin
            len_d   = score;
            here_d  = score;
            tcnt_d  = score;
            tr_d    = cnt_q;
            tc_d    = cnt_q;
            state_d = S_TB_RD;
          end
        end
      end

      S_TB_RD: begin
        if ((tcnt_q == '0) || (tr_q == '0) || (tc_q == '0)) begin
          ka_d    = '0;
          ia_d    = '0;
          kb_d    = '0;
          ib_d    = '0;
          state_d = S_SC_RD;
        end else begin
          tab_ra0 = {IDXW'(tr_q - CNTW'(2)), IDXW'(tc_q - 1'b1)};
          a_raddr = IDXW'(tr_q - 1'b1);
          state_d = S_TB_EV;
        end
      end

      S_TB_EV: begin
        // Prefer moving up, then left; otherwise the cell is a match: record it, go diagonal.
        if (up_v == here_q) begin
          tr_d = tr_q - 1'b1;
        end else if (left_v == here_q) begin
          tc_d = tc_q - 1'b1;
        end else begin
          sub_we = 1'b1;
          tr_d   = tr_q - 1'b1;
          tc_d   = tc_q - 1'b1;
          tcnt_d = tcnt_q - 1'b1;
          here_d = here_q - 1'b1;
        end
        state_d = S_TB_RD;
      end

      S_SC_RD: begin
        if (!act_a && !act_b) begin
          ek_d    = '0;
          state_d = S_EM_RD;
        end else begin
          state_d = S_SC_EV;
        end
      end

      S_SC_EV: begin
        if (act_a) begin
          if (a_rd_q == sa_rd_q) begin
            pa_we = 1'b1;
            ia_d  = ia_q + 1'b1;
          end
          ka_d = ka_q + 1'b1;
        end
        if (act_b) begin
          if (b_rd_q == sb_rd_q) begin
            pb_we = 1'b1;
            ib_d  = ib_q + 1'b1;
          end
          kb_d = kb_q + 1'b1;
        end
        state_d = S_SC_RD;
      end

      S_EM_RD: begin
        state_d = S_EM_LD;
      end

      S_EM_LD: begin
        out_ld  = 1'b1;
        ov_d    = 1'b1;
        state_d = S_EM_WT;
      end

      S_EM_WT: begin
        // Hold the result until taken; the final one closes the run.
        if (out_o.ready) begin
          ov_d = 1'b0;
          if (oend_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            ek_d    = ek_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      iss_q   <= 1'b0;
      cvld_q  <= 1'b0;
      ov_q    <= 1'b0;
      rr_q    <= '0;
      rc_q    <= '0;
      cr_q    <= '0;
      cc_q    <= '0;
      len_q   <= '0;
      tr_q    <= '0;
      tc_q    <= '0;
      tcnt_q  <= '0;
      here_q  <= '0;
      ka_q    <= '0;
      ia_q    <= '0;
      kb_q    <= '0;
      ib_q    <= '0;
      ek_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      iss_q   <= iss_d;
      cvld_q  <= cvld_d;
      ov_q    <= ov_d;
      rr_q    <= rr_d;
      rc_q    <= rc_d;
      cr_q    <= cr_d;
      cc_q    <= cc_d;
      len_q   <= len_d;
      tr_q    <= tr_d;
      tc_q    <= tc_d;
      tcnt_q  <= tcnt_d;
      here_q  <= here_d;
      ka_q    <= ka_d;
      ia_q    <= ia_d;
      kb_q    <= kb_d;
      ib_q    <= ib_d;
      ek_q    <= ek_d;
    end
  end

  // Output register: capture one result transaction.
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      olen_q <= LEN_FIELD_W'(len_q);
      opa_q  <= (len_q == '0) ? '0 : POS_FIELD_W'(pa_rd_q);
      opb_q  <= (len_q == '0) ? '0 : POS_FIELD_W'(pb_rd_q);
      opv_q  <= (len_q != '0);
      oovf_q <= ovf_q;
      oend_q <= em_last;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.lcs_length = olen_q;
  assign out_o.pos_a      = opa_q;
  assign out_o.pos_b      = opb_q;
  assign out_o.pair_valid = opv_q;
  assign out_o.overflow   = oovf_q;
  assign out_o.run_end    = oend_q;

  // ---------------------------------------------------------------------------------------------
  // Memories, registered read data
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_a_q[IDXW'(cnt_q)] <= EW'(in_i.elem_a);
      seq_b_q[IDXW'(cnt_q)] <= EW'(in_i.elem_b);
    end
    a_rd_q <= seq_a_q[a_raddr];
    b_rd_q <= seq_b_q[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_q[tab_waddr] <= score;
    end
    tab_rd0_q <= tab_q[tab_ra0];
    tab_rd1_q <= tab_q[tab_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (sub_we) begin
      sub_q[IDXW'(tcnt_q - 1'b1)] <= a_rd_q;
    end
    sa_rd_q <= sub_q[IDXW'(ia_q)];
    sb_rd_q <= sub_q[IDXW'(ib_q)];
  end

  always_ff @(posedge clk_i) begin
    if (pa_we) begin
      pa_q[IDXW'(ia_q)] <= IDXW'(ka_q);
    end
    if (pb_we) begin
      pb_q[IDXW'(ib_q)] <= IDXW'(kb_q);
    end
    pa_rd_q <= pa_q[IDXW'(ek_q)];
    pb_rd_q <= pb_q[IDXW'(ek_q)];
  end

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  `LCSP_ASSERT(a_no_load_while_emit, !(in_i.ready && out_o.valid))
  `LCSP_ASSERT(a_count_in_range, cnt_q <= CNTW'(MAX_LEN))
  `LCSP_ASSERT(a_run_end_reopens, (out_o.valid && out_o.ready && out_o.run_end) |=> in_i.ready)
  `LCSP_ASSERT(a_empty_is_single, (out_o.valid && !out_o.pair_valid) |-> (out_o.lcs_length == '0 && out_o.run_end))
  `LCSP_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !out_o.valid)

endmodule

FILE: dv/lcs_result_checker.sv
// Checker that predicts and compares the LCS length and position results.
module lcs_result_checker import lcsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lcsp_in_if   in_ch,
  lcsp_out_if  out_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int MAX_PAIRS = MAX_LEN_DEF;

  typedef struct packed {
    logic [LEN_FIELD_W-1:0] lcs_length;
    logic [POS_FIELD_W-1:0] pos_a;
    logic [POS_FIELD_W-1:0] pos_b;
    logic                   pair_valid;
    logic                   overflow;
    logic                   run_end;
  } lcs_result_t;

  logic [ELEM_FIELD_W-1:0] held_a [MAX_PAIRS];
  logic [ELEM_FIELD_W-1:0] held_b [MAX_PAIRS];
  int                      held_count;
  logic                    dropped_seen;
  lcs_result_t             expected_results [$];
  int                      mismatches;

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Store one pair; on last, solve the run and queue its results.
  task automatic absorb_pair(input logic [ELEM_FIELD_W-1:0] a, input logic [ELEM_FIELD_W-1:0] b,
                             input logic lst);
    int                      n, len, cnt, r, c, k, ind, emit;
    int                      score [0:MAX_PAIRS][0:MAX_PAIRS];
    logic [ELEM_FIELD_W-1:0] subseq [MAX_PAIRS];
    int                      pa [MAX_PAIRS];
    int                      pb [MAX_PAIRS];
    lcs_result_t             res;
    if (held_count < MAX_PAIRS) begin
      held_a[held_count] = a;
      held_b[held_count] = b;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!lst) return;

    n = held_count;
    for (r = 0; r <= n; r++) begin
      for (c = 0; c <= n; c++) begin
        if (r == 0 || c == 0) score[r][c] = 0;
        else if (held_a[r-1] == held_b[c-1]) score[r][c] = score[r-1][c-1] + 1;
        else score[r][c] = (score[r-1][c] > score[r][c-1]) ? score[r-1][c] : score[r][c-1];
      end
    end

    // Walk back from the corner, preferring up, then left, then diagonal.
    len = score[n][n];
    cnt = len;
    r = n;
    c = n;
    while (cnt > 0 && r > 0 && c > 0) begin
      if (score[r-1][c] == score[r][c]) begin
        r--;
      end else if (score[r][c-1] == score[r][c]) begin
        c--;
      end else begin
        subseq[cnt-1] = held_a[r-1];
        r--;
        c--;
        cnt--;
      end
    end

    ind = 0;
    for (k = 0; k < n && ind < len; k++)
      if (held_a[k] == subseq[ind]) begin
        pa[ind] = k;
        ind++;
      end
    ind = 0;
    for (k = 0; k < n && ind < len; k++)
      if (held_b[k] == subseq[ind]) begin
        pb[ind] = k;
        ind++;
      end

    if (len == 0) begin
      res = '0;
      res.overflow = dropped_seen;
      res.run_end = 1'b1;
      expected_results.insert(expected_results.size(), res);
    end else begin
      emit = (len < RESULT_CAP) ? len : RESULT_CAP;
      for (k = 0; k < emit; k++) begin
        res.lcs_length = LEN_FIELD_W'(len);
        res.pos_a      = POS_FIELD_W'(pa[k]);
        res.pos_b      = POS_FIELD_W'(pb[k]);
        res.pair_valid = 1'b1;
        res.overflow   = dropped_seen;
        res.run_end    = (k + 1 == emit);
        expected_results.insert(expected_results.size(), res);
      end
    end
    held_count = 0;
    dropped_seen = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcs_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      dropped_seen = 1'b0;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_pair(in_ch.elem_a, in_ch.elem_b, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: lcs_length %0d pos_a %0d pos_b %0d",
                 out_ch.lcs_length, out_ch.pos_a, out_ch.pos_b);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("lcs_length", want.lcs_length, out_ch.lcs_length);
          check_field("pos_a", want.pos_a, out_ch.pos_a);
          check_field("pos_b", want.pos_b, out_ch.pos_b);
          check_field("pair_valid", want.pair_valid, out_ch.pair_valid);
          check_field("overflow", want.overflow, out_ch.overflow);
          check_field("run_end", want.run_end, out_ch.run_end);
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: dv/tb_lcs_length_and_positions_unit.sv
// Testbench top: drives pair transactions and result backpressure, and gives the verdict.
module tb_lcs_length_and_positions_unit import lcsp_pkg::*; ();

  localparam int ITEMS       = 450;
  localparam int WATCHDOG    = 20000;  // cycles with no transaction on either channel
  localparam int HOLD_CYCLES = 600;    // long receiver hold-off to fill the block up
  localparam int DRAIN       = 100;    // cycles to watch for stray results at the end
  localparam int RUN_MAX     = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcsp_in_if  in_ch ();
  lcsp_out_if out_ch ();

  int fail_count;
  int pending;

  lcs_length_and_positions_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lcs_result_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shared knobs between the sender and the receiver process.
  bit idle_on = 1'b1;
  int hold_requests = 0;

  int                      items_sent;
  int                      run_idx;
  int                      run_len;
  int                      kind;
  int                      alph;
  bit                      wide;
  logic [ELEM_FIELD_W-1:0] base;
  logic [ELEM_FIELD_W-1:0] run_a [RUN_MAX];
  logic [ELEM_FIELD_W-1:0] run_b [RUN_MAX];

  // Offer one pair transaction, idling at random first, and hold it until accepted.
  // Valid stays high across back-to-back transactions: only one assignment per step.
  task automatic send_pair(input logic [ELEM_FIELD_W-1:0] a, input logic [ELEM_FIELD_W-1:0] b,
                           input logic lst);
    while (idle_on && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.elem_a <= a;
    in_ch.elem_b <= b;
    in_ch.last   <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until the checker holds no expectation.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Draw an element: full-range, or a few values around a base so matches are common.
  function automatic logic [ELEM_FIELD_W-1:0] pick_elem(bit full, logic [ELEM_FIELD_W-1:0] b0,
                                                        int n_vals);
    if (full) return ELEM_FIELD_W'($urandom);
    return b0 ^ ELEM_FIELD_W'($urandom_range(n_vals - 1));
  endfunction

  // Receiver: random backpressure, plus a long hold-off whenever the sender asks.
  always @(posedge clk_i) begin
    int hold_served;
    int hold_left;
    if (!rst_ni) begin
      hold_served = 0;
      hold_left = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 33);
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG) begin
        $display("lcs_length_and_positions_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.elem_a <= '0;
    in_ch.elem_b <= '0;
    in_ch.last   <= 1'b0;
    rst_ni       <= 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single matching pair, single mismatch (empty answer), extreme values.
    send_pair(16'h1234, 16'h1234, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    // Reversed sequences: the traceback has to pick among equal-score paths.
    send_pair(16'd1, 16'd4, 1'b0);
    send_pair(16'd2, 16'd3, 1'b0);
    send_pair(16'd3, 16'd2, 1'b0);
    send_pair(16'd4, 16'd1, 1'b1);
    // Alternating values shifted by one: greedy positions differ between the sides.
    send_pair(16'd5, 16'd7, 1'b0);
    send_pair(16'd7, 16'd5, 1'b0);
    send_pair(16'd5, 16'd7, 1'b0);
    send_pair(16'd7, 16'd5, 1'b0);
    send_pair(16'd5, 16'd7, 1'b1);
    // Rotated sequence.
    send_pair(16'hA5A5, 16'h5A5A, 1'b0);
    send_pair(16'hBEEF, 16'hA5A5, 1'b0);
    send_pair(16'h5A5A, 16'hBEEF, 1'b1);

    // Random runs until the item budget is spent.
    run_idx = 0;
    while (items_sent < ITEMS) begin
      // Hold off the receiver early on while runs keep coming.
      if (run_idx == 2) hold_requests++;
      // Run a stretch with no idling on either side.
      idle_on = !(run_idx >= 12 && run_idx < 20);
      // Pause the sender once until every result is back.
      if (run_idx == 25) wait_drained();

      kind = $urandom_range(99);
      wide = ($urandom_range(3) == 0);
      base = ELEM_FIELD_W'($urandom);
      alph = $urandom_range(6, 1);
      if (kind < 6) begin
        // Identical full-length sequences: the longest answer, every result slot used.
        run_len = MAX_LEN_DEF;
        for (int i = 0; i < run_len; i++) begin
          run_a[i] = pick_elem(wide, base, alph);
          run_b[i] = run_a[i];
        end
      end else begin
        if (kind < 12) run_len = $urandom_range(RUN_MAX, MAX_LEN_DEF + 1);  // dropped pairs
        else if (kind < 20) run_len = $urandom_range(MAX_LEN_DEF, 9);
        else run_len = $urandom_range(8, 1);
        for (int i = 0; i < run_len; i++) begin
          run_a[i] = pick_elem(wide, base, alph);
          run_b[i] = pick_elem(wide, base, alph);
        end
      end
      for (int i = 0; i < run_len; i++) send_pair(run_a[i], run_b[i], i == run_len - 1);
      run_idx++;
    end

    // Let the last results out, then watch for strays.
    idle_on = 1'b1;
    wait_drained();
    repeat (DRAIN) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("lcs_length_and_positions_unit regression: pass");
    end else begin
      $display("lcs_length_and_positions_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lcsp_pkg.sv
design/lcsp_ifs.sv
design/lcsp_cell_unit.sv
design/lcs_length_and_positions_unit.sv
dv/lcs_result_checker.sv
dv/tb_lcs_length_and_positions_unit.sv
